@@ hw/rtl/cbf_pkg.sv @@
// Shared constants, types and codes for the counting Bloom filter.
// Used by cbf_mod_unit, counting_bloom_filter_top and cbf_checker.
package cbf_pkg;

  localparam int unsigned MAX_FILTER_BITS = 65536;
  localparam int unsigned HASH_WORDS      = 4;
  localparam int unsigned COUNTER_WIDTH   = 4;

  localparam int unsigned IDX_W    = $clog2(MAX_FILTER_BITS);
  localparam int unsigned SIZE_W   = IDX_W + 1;
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned STEP_W   = $clog2(HASH_W);
  localparam int unsigned HSEL_W   = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
  localparam int unsigned PORT_WORDS = 4;

  localparam int unsigned FILTER_BITS_W  = 17;
  localparam int unsigned HASH_COUNT_W   = 3;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 17;
  localparam int unsigned FILTER_BITS_RST = 65536;
  localparam int unsigned HASH_COUNT_RST  = 4;

  localparam logic [COUNTER_WIDTH-1:0] COUNTER_MAX = 4'hF;

  typedef logic [1:0] action_t;
  localparam action_t ACT_ADD    = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_TEST   = 2'd2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_FILTER_BITS   = 2'd0;
  localparam cfg_index_t REG_HASH_COUNT    = 2'd1;
  localparam cfg_index_t REG_COUNTING_MODE = 2'd2;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_res_t;

  typedef struct packed {
    logic                     member;
    logic [COUNTER_WIDTH-1:0] count;
  } entry_t;

endpackage

@@ hw/rtl/cbf_mod_unit.sv @@
// Bit-serial restoring remainder of a 64-bit hash word by the filter size.
// Depends on cbf_pkg.
module cbf_mod_unit import cbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [HASH_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output mod_res_t          res_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [HASH_W-1:0] dvd_q;
  logic [SIZE_W-1:0] rem_q;
  logic [SIZE_W-1:0] trial;
  logic [SIZE_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q[IDX_W-1:0], dvd_q[HASH_W-1]};
    rem_d = (trial >= divisor_i) ? trial - divisor_i : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        done_q <= (step_q == STEP_W'(HASH_W - 1));
        if (step_q == STEP_W'(HASH_W - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q[IDX_W-1:0];

endmodule

@@ hw/rtl/counting_bloom_filter_top.sv @@
// Counting Bloom filter: sequencer, register file and filter memory.
// Depends on cbf_pkg and cbf_mod_unit.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_stall_o   action_i, hash_word_0_i .. hash_word_3_i
//   out      out_valid_o / out_stall_i found_o, status_o
//   cfg      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// An item that touches the filter runs, for each hash word used, the 64-step
// remainder unit followed by one read-modify-write of memory, then the done
// state; an item that does nothing goes straight to the done state.
// After reset a clearing pass writes all 65536 entries, one per cycle; input
// stays stalled until the pass ends. A result waits in an output register,
// so a new item is taken while out_stall_i holds the previous result.
module counting_bloom_filter_top import cbf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic [HASH_W-1:0]      hash_word_0_i,
  input  logic [HASH_W-1:0]      hash_word_1_i,
  input  logic [HASH_W-1:0]      hash_word_2_i,
  input  logic [HASH_W-1:0]      hash_word_3_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   found_o,
  output logic                   status_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RMW,
    ST_DONE
  } state_e;

  state_e                   state_q;
  logic [IDX_W-1:0]         clr_idx_q;
  logic [FILTER_BITS_W-1:0] filter_bits_q;
  logic [HASH_COUNT_W-1:0]  hash_count_q;
  logic                     counting_mode_q;

  action_t                  action_q;
  logic [HASH_W-1:0]        hash_q [HASH_WORDS];
  logic [HASH_W-1:0]        in_words [PORT_WORDS];
  logic [HSEL_W-1:0]        sel_q;
  logic [HSEL_W-1:0]        last_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     found_q;
  logic                     status_q;
  logic                     out_valid_q;
  logic                     out_found_q;
  logic                     out_status_q;

  logic [SIZE_W-1:0]        eff_size;
  logic [HSEL_W-1:0]        last_d;
  logic                     in_accept;
  logic                     refused;
  logic                     noop;
  logic                     mod_start;
  logic [HASH_W-1:0]        mod_dividend;
  mod_res_t                 mod_res;

  entry_t                   mem_q [MAX_FILTER_BITS];
  entry_t                   rd_q;
  entry_t                   upd;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  entry_t                   mem_wdata;

  assign in_words[0] = hash_word_0_i;
  assign in_words[1] = hash_word_1_i;
  assign in_words[2] = hash_word_2_i;
  assign in_words[3] = hash_word_3_i;

  always_comb begin
    if (filter_bits_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(filter_bits_q) > 32'(MAX_FILTER_BITS)) begin
      eff_size = SIZE_W'(MAX_FILTER_BITS);
    end else begin
      eff_size = SIZE_W'(filter_bits_q);
    end
    if (hash_count_q == '0) begin
      last_d = '0;
    end else if (32'(hash_count_q) > 32'(HASH_WORDS)) begin
      last_d = HSEL_W'(HASH_WORDS - 1);
    end else begin
      last_d = HSEL_W'(hash_count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bits_q   <= FILTER_BITS_W'(FILTER_BITS_RST);
      hash_count_q    <= HASH_COUNT_W'(HASH_COUNT_RST);
      counting_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FILTER_BITS:   filter_bits_q   <= cfg_wdata_i[FILTER_BITS_W-1:0];
        REG_HASH_COUNT:    hash_count_q    <= cfg_wdata_i[HASH_COUNT_W-1:0];
        REG_COUNTING_MODE: counting_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    refused = 1'b0;
    noop    = 1'b0;
    case (action_i)
      ACT_ADD, ACT_TEST: noop = 1'b0;
      ACT_REMOVE: begin
        refused = !counting_mode_q;
        noop    = !counting_mode_q;
      end
      default: noop = 1'b1;
    endcase
  end

  assign mod_start    = (in_accept && !noop) || (state_q == ST_RMW && sel_q != last_q);
  assign mod_dividend = in_accept ? hash_word_0_i : hash_q[sel_q + 1'b1];

  cbf_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (eff_size),
    .res_o      (mod_res)
  );

  always_comb begin
    upd = rd_q;
    case (action_q)
      ACT_ADD: begin
        upd.member = 1'b1;
        if (counting_mode_q && rd_q.count != COUNTER_MAX) begin
          upd.count = rd_q.count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (rd_q.count != '0 && rd_q.count != COUNTER_MAX) begin
          upd.count = rd_q.count - 1'b1;
        end
        if (upd.count == '0) begin
          upd.member = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign mem_we    = (state_q == ST_CLEAR) ||
                     (state_q == ST_RMW && (action_q inside {ACT_ADD, ACT_REMOVE}));
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_idx_q : idx_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : upd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mod_res.rem];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash_q[i] <= in_words[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      action_q     <= ACT_ADD;
      sel_q        <= '0;
      last_q       <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      status_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_status_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == IDX_W'(MAX_FILTER_BITS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            action_q <= action_i;
            sel_q    <= '0;
            last_q   <= last_d;
            found_q  <= (action_i == ACT_TEST);
            status_q <= refused;
            state_q  <= noop ? ST_DONE : ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_res.done) begin
            idx_q   <= mod_res.rem;
            state_q <= ST_RMW;
          end
        end
        ST_RMW: begin
          if (action_q == ACT_TEST && !rd_q.member) begin
            found_q <= 1'b0;
          end
          if (sel_q == last_q) begin
            state_q <= ST_DONE;
          end else begin
            sel_q   <= sel_q + 1'b1;
            state_q <= ST_MOD;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_found_q  <= found_q;
            out_status_q <= status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign status_o    = out_status_q;

endmodule

@@ hw/rtl/cbf_checker.sv @@
// Port-level checks for counting_bloom_filter_top, attached by bind.
// Depends on cbf_pkg.
module cbf_checker import cbf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic found_o,
  input logic status_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transfer");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

  a_refused_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !found_o)
    else $error("refused remove reports found");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind counting_bloom_filter_top cbf_checker u_cbf_checker (.*);
